>>> hdl/gcd_pkg.sv
// Package for the great-circle distance unit: widths, fixed-point constants,
// the CORDIC arctangent table and the Q30 product helper. No dependencies.
package gcd_pkg;

  localparam int unsigned NumLanes   = 4;   // sin dlat/2, sin dlon/2, cos lat a, cos lat b
  localparam int unsigned DivCells   = 5;   // 8 dividend bits per cell, 40 bits
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned SqrtCells  = 31;  // one root bit per cell

  localparam logic [31:0] PiQ30       = 32'hC90FDAA2;
  localparam logic [33:0] CordicGain  = 34'd652032874;
  localparam logic [30:0] QOne        = 31'd1073741824;
  localparam logic [29:0] QHalf       = 30'd536870912;
  localparam logic [25:0] TurnQ16     = 26'd23592960;
  localparam logic [25:0] HalfTurnQ16 = 26'd11796480;
  localparam logic [23:0] QuarterQ16  = 24'd5898240;
  localparam logic [23:0] HalfDenCos  = 24'd5898240;   // (180*65536)/2
  localparam logic [23:0] HalfDenHalf = 24'd11796480;  // (360*65536)/2
  localparam logic [23:0] TwoRMetres  = 24'd12742000;
  localparam logic [24:0] MaxDist     = 25'd20015087;
  // 180*65536 = 45 * 2^18; n / 45 = (n * ceil(2^44 / 45)) >> 44, exact below 2^38
  localparam logic [38:0] Div45Recip  = 39'd390937467654;
  localparam int unsigned Div45Shift  = 44;

  typedef enum logic [1:0] {
    LaneDlat = 2'd0,
    LaneDlon = 2'd1,
    LaneCosA = 2'd2,
    LaneCosB = 2'd3
  } lane_e;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      5'd24: r = 34'sh00000003F;
      5'd25: r = 34'sh00000001F;
      5'd26: r = 34'sh00000000F;
      5'd27: r = 34'sh000000007;
      5'd28: r = 34'sh000000003;
      5'd29: r = 34'sh000000001;
      default: r = 34'sh0;
    endcase
    return r;
  endfunction

  // Q30 product of two magnitudes, rounded to nearest
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(QHalf);
    return p[60:30];
  endfunction

  // clamp a signed Q30 value to [0, 1]
  function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
    logic [30:0] r;
    if (v < 34'sd0) begin
      r = '0;
    end else if (v > $signed({3'b000, QOne})) begin
      r = QOne;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  // angle difference folded into [0, 180] degrees, magnitude only
  function automatic logic [23:0] fold_abs(input logic signed [25:0] v);
    logic [25:0] m;
    m = v[25] ? 26'(-v) : 26'(v);
    if (m >= TurnQ16) begin
      m = m - TurnQ16;
    end
    if (m > HalfTurnQ16) begin
      m = TurnQ16 - m;
    end
    return m[23:0];
  endfunction

endpackage

>>> hdl/gcd_div_cell.sv
// One cell of the divide-by-45 chain: one dividend byte times the reciprocal,
// added into the running product. Depends on gcd_pkg.
module gcd_div_cell import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [2:0]  slice_i,
  input  logic [39:0] num_i,
  input  logic [79:0] acc_i,
  output logic [39:0] num_o,
  output logic [79:0] acc_o
);

  logic [47:0] part;
  logic [79:0] acc_d, acc_q;
  logic [39:0] num_q;

  // partial product of this byte, placed at its weight
  always_comb begin
    part  = 48'(num_i[{slice_i, 3'b000} +: 8]) * 48'(Div45Recip);
    acc_d = acc_i + (80'(part) << {slice_i, 3'b000});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_i;
      acc_q <= acc_d;
    end
  end

  assign num_o = num_q;
  assign acc_o = acc_q;

endmodule

>>> hdl/gcd_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// Depends on gcd_pkg for the arctangent table.
module gcd_cordic_cell import gcd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [4:0]         step_i,
  input  logic               vect_i,
  input  logic signed [33:0] x_i,
  input  logic signed [33:0] y_i,
  input  logic signed [33:0] z_i,
  output logic signed [33:0] x_o,
  output logic signed [33:0] y_o,
  output logic signed [33:0] z_o
);

  logic signed [33:0] dx, dy, at;
  logic               sub;
  logic signed [33:0] x_d, y_d, z_d, x_q, y_q, z_q;

  always_comb begin
    dx  = y_i >>> step_i;
    dy  = x_i >>> step_i;
    at  = atan_q30(step_i);
    // vectoring drives y to zero, rotation drives z to zero
    sub = vect_i ? !(y_i > 34'sd0) : (z_i >= 34'sd0);
    x_d = sub ? x_i - dx : x_i + dx;
    y_d = sub ? y_i + dy : y_i - dy;
    z_d = sub ? z_i - at : z_i + at;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> hdl/gcd_sqrt_cell.sv
// One bit of the digit-by-digit integer square root, registered.
// Depends on gcd_pkg.
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [4:0]  bit_i,
  input  logic [60:0] rem_i,
  input  logic [30:0] root_i,
  output logic [60:0] rem_o,
  output logic [30:0] root_o
);

  logic [61:0] trial;
  logic [60:0] rem_d, rem_q;
  logic [30:0] root_d, root_q;

  // trial = (2*root + 2^b) * 2^b, root holding only bits above b
  always_comb begin
    trial = (62'(root_i) << ({1'b0, bit_i} + 6'd1)) | (62'd1 << {bit_i, 1'b0});
    rem_d  = rem_i;
    root_d = root_i;
    if ({1'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[60:0];
      root_d = root_i | (31'd1 << bit_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> hdl/great_circle_distance_unit.sv
// Great-circle distance unit, haversine formula, fully pipelined.
// Depends on gcd_pkg, gcd_div_cell, gcd_cordic_cell and gcd_sqrt_cell.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o with lat_a_i, lon_a_i, lat_b_i,
//   lon_b_i in signed degrees with 16 fraction bits. A transfer happens when
//   valid and ready are both high.
//   Output channel: out_valid_o / out_ready_i with distance_m_o, metres on a
//   6371 km sphere, rounded to nearest.
//   One item is taken every cycle while the output is not stalled. The depth
//   is set by the chains of cells: five reciprocal-multiply cells for the
//   divide by 45 in the degree to radian step, 30 CORDIC rotation cells, 31
//   square root cells and 30 CORDIC vectoring cells, plus the input, fold,
//   multiply, haversine and output registers.
//   The whole pipeline advances together. While a result sits at the output
//   and the receiver stalls, in_ready_o is low and every stage holds; it
//   rises again in the cycle the result is taken, so no rate is lost with
//   out_ready_i held high.
//   Reset clears all stage valid flags; the block takes items in the first
//   cycle after reset is released. No state survives between items.
module great_circle_distance_unit import gcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] lat_a_i,
  input  logic signed [24:0] lon_a_i,
  input  logic signed [23:0] lat_b_i,
  input  logic signed [24:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [24:0]        distance_m_o
);

  localparam int unsigned NumStages = 3 + DivCells + CordicSteps + 3 + SqrtCells
                                      + CordicSteps + 2;
  localparam int unsigned NegTaps   = 3 + DivCells + CordicSteps;

  logic en;
  logic [NumStages-1:0] vld_q;

  assign en         = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // input register
  logic signed [23:0] la_q, lb_q;
  logic signed [24:0] oa_q, ob_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      la_q <= lat_a_i;
      oa_q <= lon_a_i;
      lb_q <= lat_b_i;
      ob_q <= lon_b_i;
    end
  end

  // folded angle magnitudes, cosine sign flags
  logic [23:0] mag_d [NumLanes];
  logic [23:0] mag_q [NumLanes];
  logic [23:0] ra, rb;
  logic        na, nb;
  logic        neg_q [NegTaps];

  always_comb begin
    ra = la_q[23] ? 24'(-la_q) : 24'(la_q);
    rb = lb_q[23] ? 24'(-lb_q) : 24'(lb_q);
    na = ra > QuarterQ16;
    nb = rb > QuarterQ16;
    mag_d[LaneDlat] = fold_abs(26'(lb_q) - 26'(la_q));
    mag_d[LaneDlon] = fold_abs(26'(ob_q) - 26'(oa_q));
    mag_d[LaneCosA] = na ? HalfTurnQ16[23:0] - ra : ra;
    mag_d[LaneCosB] = nb ? HalfTurnQ16[23:0] - rb : rb;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q      <= mag_d;
      neg_q[0]   <= na ^ nb;
      for (int k = 1; k < NegTaps; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // radians: round(mag * pi / den), den = 45 * 2^e
  logic [55:0] prod_q [NumLanes];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[LaneDlat] <= 56'(mag_q[LaneDlat]) * 56'(PiQ30) + 56'(HalfDenHalf);
      prod_q[LaneDlon] <= 56'(mag_q[LaneDlon]) * 56'(PiQ30) + 56'(HalfDenHalf);
      prod_q[LaneCosA] <= 56'(mag_q[LaneCosA]) * 56'(PiQ30) + 56'(HalfDenCos);
      prod_q[LaneCosB] <= 56'(mag_q[LaneCosB]) * 56'(PiQ30) + 56'(HalfDenCos);
    end
  end

  logic [39:0] dnum [NumLanes][DivCells+1];
  logic [79:0] dacc [NumLanes][DivCells+1];
  logic signed [33:0] cx [NumLanes][CordicSteps+1];
  logic signed [33:0] cy [NumLanes][CordicSteps+1];
  logic signed [33:0] cz [NumLanes][CordicSteps+1];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    if (l < 2) begin : g_half
      assign dnum[l][0] = {3'b000, prod_q[l][55:19]};
    end else begin : g_full
      assign dnum[l][0] = {2'b00, prod_q[l][55:18]};
    end
    assign dacc[l][0] = '0;

    for (genvar k = 0; k < DivCells; k++) begin : g_div
      gcd_div_cell u_div (
        .clk_i   (clk_i),
        .en_i    (en),
        .slice_i (3'(k)),
        .num_i   (dnum[l][k]),
        .acc_i   (dacc[l][k]),
        .num_o   (dnum[l][k+1]),
        .acc_o   (dacc[l][k+1])
      );
    end

    assign cx[l][0] = $signed(CordicGain);
    assign cy[l][0] = '0;
    assign cz[l][0] = $signed({2'b00, dacc[l][DivCells][Div45Shift +: 32]});

    for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
      gcd_cordic_cell u_rot (
        .clk_i  (clk_i),
        .en_i   (en),
        .step_i (5'(k)),
        .vect_i (1'b0),
        .x_i    (cx[l][k]),
        .y_i    (cy[l][k]),
        .z_i    (cz[l][k]),
        .x_o    (cx[l][k+1]),
        .y_o    (cy[l][k+1]),
        .z_o    (cz[l][k+1])
      );
    end
  end

  // haversine term a
  logic [30:0] slat_q, slon_q, cab_q, slat2_q, term_q;
  logic        neg2_q;
  logic signed [32:0] a_sum;
  logic [30:0] a_d, a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      slat_q  <= mul_q30(clamp_unit(cy[LaneDlat][CordicSteps]),
                         clamp_unit(cy[LaneDlat][CordicSteps]));
      slon_q  <= mul_q30(clamp_unit(cy[LaneDlon][CordicSteps]),
                         clamp_unit(cy[LaneDlon][CordicSteps]));
      cab_q   <= mul_q30(clamp_unit(cx[LaneCosA][CordicSteps]),
                         clamp_unit(cx[LaneCosB][CordicSteps]));
      term_q  <= mul_q30(cab_q, slon_q);
      slat2_q <= slat_q;
      neg2_q  <= neg_q[NegTaps-1];
      a_q     <= a_d;
    end
  end

  always_comb begin
    a_sum = neg2_q ? $signed({2'b00, slat2_q}) - $signed({2'b00, term_q})
                   : $signed({2'b00, slat2_q}) + $signed({2'b00, term_q});
    a_d   = clamp_unit(34'(a_sum));
  end

  // square roots of a and 1 - a, Q30 results
  logic [60:0] srem [2][SqrtCells+1];
  logic [30:0] sroot [2][SqrtCells+1];

  assign srem[0][0]  = {a_q, 30'd0};
  assign srem[1][0]  = {QOne - a_q, 30'd0};
  assign sroot[0][0] = '0;
  assign sroot[1][0] = '0;

  for (genvar r = 0; r < 2; r++) begin : g_sq
    for (genvar k = 0; k < SqrtCells; k++) begin : g_bit
      gcd_sqrt_cell u_sqrt (
        .clk_i  (clk_i),
        .en_i   (en),
        .bit_i  (5'(SqrtCells - 1 - k)),
        .rem_i  (srem[r][k]),
        .root_i (sroot[r][k]),
        .rem_o  (srem[r][k+1]),
        .root_o (sroot[r][k+1])
      );
    end
  end

  // central angle atan2(sqrt(a), sqrt(1-a))
  logic signed [33:0] vx [CordicSteps+1];
  logic signed [33:0] vy [CordicSteps+1];
  logic signed [33:0] vz [CordicSteps+1];

  assign vx[0] = $signed({3'b000, sroot[1][SqrtCells]});
  assign vy[0] = $signed({3'b000, sroot[0][SqrtCells]});
  assign vz[0] = '0;

  for (genvar k = 0; k < CordicSteps; k++) begin : g_vec
    gcd_cordic_cell u_vec (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (5'(k)),
      .vect_i (1'b1),
      .x_i    (vx[k]),
      .y_i    (vy[k]),
      .z_i    (vz[k]),
      .x_o    (vx[k+1]),
      .y_o    (vy[k+1]),
      .z_o    (vz[k+1])
    );
  end

  // scale to metres
  logic [32:0] zpos;
  logic [56:0] dprod_q;
  logic [24:0] dist_q;

  assign zpos = vz[CordicSteps][33] ? 33'd0 : vz[CordicSteps][32:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dprod_q <= 57'(zpos) * 57'(TwoRMetres) + 57'(QHalf);
      dist_q  <= (dprod_q[56:30] > 27'(MaxDist)) ? MaxDist : dprod_q[54:30];
    end
  end

  assign out_valid_o  = vld_q[NumStages-1];
  assign distance_m_o = dist_q;

endmodule

>>> tb/gcd_checker.sv
`timescale 1ns / 1ps
// Checker for the great-circle distance unit: watches both channels, predicts
// each distance with its own fixed-point haversine and compares in order.
// Depends on nothing but the port widths of great_circle_distance_unit.
module gcd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [23:0] lat_a_i,
  input  logic signed [24:0] lon_a_i,
  input  logic signed [23:0] lat_b_i,
  input  logic signed [24:0] lon_b_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [24:0]        distance_m_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 seen_o
);

  localparam longint OneQ30   = 64'd1073741824;
  localparam longint HalfQ30  = 64'd536870912;
  localparam longint PiQ30    = 64'd3373259426;
  localparam longint GainQ30  = 64'd652032874;
  localparam longint FullTurn = 64'd23592960;
  localparam longint HalfTurn = 64'd11796480;
  localparam longint Quarter  = 64'd5898240;
  localparam longint TwoR     = 64'd12742000;
  localparam longint DistMax  = 64'd20015087;

  longint arctan_steps [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

  logic [24:0] distance_q [$];
  int          fails = 0;
  int          seen = 0;

  function automatic longint floor_shift(longint v, int s);
    longint mag;
    if (v >= 0) return v >>> s;
    mag = -v;
    return -((mag + ((64'sd1 <<< s) - 1)) >>> s);
  endfunction

  // fold into [-180,180) degrees, magnitude
  function automatic longint fold_mag(longint v);
    longint r;
    r = v % FullTurn;
    if (r < 0) r += FullTurn;
    if (r >= HalfTurn) r -= FullTurn;
    return (r < 0) ? -r : r;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > OneQ30) return OneQ30;
    return v;
  endfunction

  function automatic longint q30_product(longint a, longint b);
    logic [63:0] p;
    p = a * b + HalfQ30;
    return longint'(p >> 30);
  endfunction

  function automatic void cordic_rotate(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GainQ30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_steps[i];
      end else begin
        x += dx; y -= dy; z += arctan_steps[i];
      end
    end
    c = unit_clamp(x);
    s = unit_clamp(y);
  endfunction

  function automatic longint to_radians(longint mag, longint den);
    logic [63:0] n;
    n = mag * PiQ30 + den / 2;
    return longint'(n / den);
  endfunction

  function automatic longint half_sine_sq(longint diff);
    longint c, s;
    cordic_rotate(to_radians(fold_mag(diff), 2 * HalfTurn), c, s);
    return q30_product(s, s);
  endfunction

  function automatic longint signed_cosine(longint lat);
    longint r, c, s;
    bit neg;
    r = fold_mag(lat);
    neg = 0;
    if (r > Quarter) begin
      neg = 1;
      r = HalfTurn - r;
    end
    cordic_rotate(to_radians(r, HalfTurn), c, s);
    return neg ? -c : c;
  endfunction

  function automatic longint int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arc_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_steps[i];
      end else begin
        x -= dx; y += dy; z -= arctan_steps[i];
      end
    end
    return z;
  endfunction

  function automatic logic [24:0] haversine_metres(longint la, longint oa, longint lb,
                                                   longint ob);
    longint slat, slon, ca, cb, ma, mb, term, a, s, t, z;
    logic [63:0] d;
    bit neg;
    slat = half_sine_sq(lb - la);
    slon = half_sine_sq(ob - oa);
    ca = signed_cosine(la);
    cb = signed_cosine(lb);
    neg = (ca < 0) != (cb < 0);
    ma = (ca < 0) ? -ca : ca;
    mb = (cb < 0) ? -cb : cb;
    term = q30_product(q30_product(ma, mb), slon);
    a = unit_clamp(slat + (neg ? -term : term));
    s = int_sqrt(a << 30);
    t = int_sqrt((OneQ30 - a) << 30);
    z = arc_angle(s, t);
    if (z < 0) z = 0;
    d = (z * TwoR + HalfQ30) >> 30;
    if (d > DistMax) d = DistMax;
    return d[24:0];
  endfunction

  always @(posedge clk_i) begin
    logic [24:0] want;
    if (rst_ni && in_valid_i && in_ready_i)
      distance_q.push_back(haversine_metres(lat_a_i, lon_a_i, lat_b_i, lon_b_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      seen <= seen + 1;
      if (distance_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result transfer: distance %0d", distance_m_i);
      end else begin
        want = distance_q.pop_front();
        if (want !== distance_m_i) begin
          fails++;
          if (fails <= 10)
            $display("distance mismatch: expected %0d, got %0d", want, distance_m_i);
        end
      end
    end
  end

  assign seen_o       = seen;
  assign fail_count_o = fails;
  assign pending_o    = distance_q.size();

endmodule

>>> tb/tb_great_circle_distance_unit.sv
`timescale 1ns / 1ps
// Top of the great-circle distance testbench: clock, reset, stimulus and verdict.
// Depends on great_circle_distance_unit and gcd_checker.
module tb_great_circle_distance_unit;

  localparam int LatMax = 5898240;
  localparam int LonMax = 11796480;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o, out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [23:0] lat_a_i, lat_b_i;
  logic signed [24:0] lon_a_i, lon_b_i;
  logic [24:0]        distance_m_o;
  int                 fail_count, pending, seen;
  bit                 steady;

  great_circle_distance_unit u_dut (.*);

  gcd_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .lat_a_i, .lon_a_i, .lat_b_i, .lon_b_i,
    .out_valid_i(out_valid_o), .out_ready_i, .distance_m_i(distance_m_o),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // receiver stalls about 30 % of the time except in the steady stretch
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 30);
  end

  function automatic int any_lat();
    return $urandom_range(2 * LatMax) - LatMax;
  endfunction

  function automatic int any_lon();
    return $urandom_range(2 * LonMax) - LonMax;
  endfunction

  // one transfer, with random idle cycles ahead of it
  task automatic send_pair(int la, int oa, int lb, int ob);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    lat_a_i    <= 24'(la);
    lon_a_i    <= 25'(oa);
    lat_b_i    <= 24'(lb);
    lon_b_i    <= 25'(ob);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int la, oa;
    in_valid_i  = 1'b0;
    lat_a_i     = '0;
    lon_a_i     = '0;
    lat_b_i     = '0;
    lon_b_i     = '0;
    steady      = 1'b0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, antipodes, poles, field extremes, wrap and beyond-pole cases
    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, LonMax);
    send_pair(0, -LonMax, 0, LonMax);
    send_pair(LatMax, 0, -LatMax, 0);
    send_pair(-LatMax, -LonMax, LatMax, LonMax);
    send_pair(LatMax, 123, LatMax, -4567890);
    send_pair(1, 1, 0, 0);
    send_pair(0, 0, 0, 1);
    send_pair(-8388608, -16777216, 8388607, 16777215);
    send_pair(8388607, 16777215, -8388608, -16777216);
    send_pair(7000000, 0, -7000000, 0);
    send_pair(-8388608, 0, 0, 0);
    send_pair(0, 16777215, 0, -16777216);
    send_pair(3000000, 11796479, 3000000, -11796480);
    send_pair(2000000, 5000000, -2000000, -6796480);
    send_pair(-3342336, 9000000, 3342336, -2796480);
    send_pair(LatMax, LonMax, LatMax - 1, LonMax);

    for (int n = 0; n < 1450; n++) begin
      steady = (n >= 500 && n < 700);
      la = any_lat();
      oa = any_lon();
      case ($urandom_range(9))
        0:       send_pair($urandom, $urandom, $urandom, $urandom); // full bit range
        1, 2:    send_pair(la, oa, la + $urandom_range(2000) - 1000,
                           oa + $urandom_range(2000) - 1000);        // short hops
        3:       send_pair(la, oa, -la, oa + LonMax + $urandom_range(200) - 100);
        default: send_pair(la, oa, any_lat(), any_lon());
      endcase
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("Covered %0d distance results: poles, antipodes, wraps, out-of-range fields,",
             seen);
    $display("short hops and random pairs, with idle and stall cycles on both channels.");
    if (fail_count == 0) begin
      $display("tb_great_circle_distance_unit: PASS");
    end else begin
      $display("tb_great_circle_distance_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_great_circle_distance_unit: FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/gcd_pkg.sv
hdl/gcd_div_cell.sv
hdl/gcd_cordic_cell.sv
hdl/gcd_sqrt_cell.sv
hdl/great_circle_distance_unit.sv
tb/gcd_checker.sv
tb/tb_great_circle_distance_unit.sv
